/* hw/rtl/mjfx_pkg.sv */
package mjfx_pkg;

  localparam int BYTE_W = 8;
  localparam int PLEN_W = 11;
  localparam int ADDR_W = 19;
  localparam int FLEN_W = 20;
  localparam int HDR_W  = 8;

  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] SOI_BYTE  = 8'hD8;
  localparam logic [BYTE_W-1:0] EOI_BYTE  = 8'hD9;

  localparam logic [FLEN_W-1:0] MIN_FRAME_RST = 20'd1000;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  byte_value;
    logic [FLEN_W-1:0]  frame_length;
    logic               last;
  } result_t;

  function automatic result_t mk_store(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] b);
    result_t r;
    r.kind         = KIND_STORE;
    r.address      = addr;
    r.byte_value   = b;
    r.frame_length = '0;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_done(logic [FLEN_W-1:0] len);
    result_t r;
    r.kind         = KIND_DONE;
    r.address      = '0;
    r.byte_value   = '0;
    r.frame_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/mjfx_front.sv */
module mjfx_front
  import mjfx_pkg::*;
#(
  parameter int MAX_PACKET = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_en,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              packet_start,
  input  logic [PLEN_W-1:0] packet_len,
  output logic              push,
  output logic [BYTE_W-1:0] push_byte
);

  localparam int LCMP_W = 12;
  localparam logic [PLEN_W-1:0] POS_MAX = '1;

  logic [PLEN_W-1:0] pos_r, pos_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [PLEN_W-1:0] held_r, held_nxt;
  logic              ok_r, ok_nxt;
  logic [PLEN_W-1:0] pos_inc;

  assign pos_inc   = (pos_r == POS_MAX) ? pos_r : pos_r + PLEN_W'(1);
  assign push_byte = data_byte;

  always_comb begin
    pos_nxt  = pos_r;
    hdr_nxt  = hdr_r;
    held_nxt = held_r;
    ok_nxt   = ok_r;
    push     = 1'b0;
    if (beat_en) begin
      if (packet_start) begin
        pos_nxt  = '0;
        hdr_nxt  = data_byte;
        held_nxt = packet_len;
        ok_nxt   = (packet_len >= PLEN_W'(2)) && (data_byte >= HDR_W'(2))
                && (PLEN_W'(data_byte) <= packet_len)
                && (LCMP_W'(packet_len) <= LCMP_W'(MAX_PACKET));
      end else begin
        pos_nxt = pos_inc;
        push    = ok_r && (pos_inc >= PLEN_W'(hdr_r)) && (pos_inc < held_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hdr_r  <= '0;
      held_r <= '0;
      ok_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      hdr_r  <= hdr_nxt;
      held_r <= held_nxt;
      ok_r   <= ok_nxt;
    end
  end

endmodule

/* hw/rtl/mjfx_queue.sv */
module mjfx_queue
  import mjfx_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [BYTE_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [BYTE_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/mjfx_back.sv */
module mjfx_back
  import mjfx_pkg::*;
#(
  parameter int MAX_FRAME = 524288
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FLEN_W-1:0] min_frame,
  input  logic              q_valid,
  input  logic [BYTE_W-1:0] q_byte,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int FC_W  = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = (FC_W > FLEN_W) ? FC_W : FLEN_W;

  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [BYTE_W-1:0] prior_r, prior_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  result_t           out_r, pend_r;
  result_t           r0, r1;
  logic [1:0]        n;
  logic [FC_W-1:0]   fc_tmp;
  logic              prev_ff;
  logic              out_free;

  assign out_free  = !out_valid_r || res_ready;
  assign q_pop     = q_valid && !pend_valid_r && out_free;
  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign prev_ff   = (prior_r == MARK_BYTE);

  // frame hunter, one queued byte per pop
  always_comb begin
    fc_nxt    = fc_r;
    prior_nxt = prior_r;
    fc_tmp    = fc_r;
    r0        = mk_done('0);
    r1        = mk_done('0);
    n         = 2'd0;
    if (q_pop) begin
      if (fc_r == '0) begin
        if (q_byte == MARK_BYTE) begin
          r0        = mk_store('0, q_byte);
          n         = 2'd1;
          fc_nxt    = FC_W'(1);
          prior_nxt = q_byte;
        end
      end else if (prev_ff && q_byte == SOI_BYTE) begin
        r0        = mk_store('0, MARK_BYTE);
        r1        = mk_store(ADDR_W'(1), SOI_BYTE);
        n         = 2'd2;
        fc_nxt    = FC_W'(2);
        prior_nxt = SOI_BYTE;
      end else if (fc_r == FC_W'(1) && q_byte != SOI_BYTE) begin
        fc_nxt = (q_byte == MARK_BYTE) ? FC_W'(1) : '0;
      end else begin
        if (fc_r < FC_W'(MAX_FRAME)) begin
          r0        = mk_store(ADDR_W'(fc_r), q_byte);
          n         = 2'd1;
          fc_tmp    = fc_r + FC_W'(1);
          prior_nxt = q_byte;
        end else begin
          fc_tmp = '0;
        end
        fc_nxt = fc_tmp;
        if (prev_ff && q_byte == EOI_BYTE) begin
          if (fc_tmp != '0 && CMP_W'(fc_tmp) >= CMP_W'(min_frame)) begin
            if (n == 2'd1) begin
              r1 = mk_done(FLEN_W'(fc_tmp));
              n  = 2'd2;
            end else begin
              r0 = mk_done(FLEN_W'(fc_tmp));
              n  = 2'd1;
            end
          end
          fc_nxt = '0;
        end
      end
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (n != 2'd0) begin
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = (n == 2'd2);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r         <= '0;
      prior_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      fc_r         <= fc_nxt;
      prior_r      <= prior_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else begin
        out_r  <= r0;
        pend_r <= r1;
      end
    end
  end

endmodule

/* hw/rtl/uvc_mjpeg_frame_extractor.sv */
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata: data_byte, packet_len; tuser: packet_start
// out_      out  out_tvalid/out_tready tdata: address, byte_value, frame_length;
//                                     tuser: kind; tlast: last
// cfg_      in   cfg_valid/cfg_ready  cfg_data: min_frame
//
// one input beat per cycle while the payload queue has room; a payload byte
// leaves the queue only while the output register is free and no result is
// pending (the single output register plus one pending slot set this)
// synchronous reset clears packet and frame state, min_frame returns to 1000
// the payload queue lets new beats in while a result waits for out_tready, until it is full
module uvc_mjpeg_frame_extractor
  import mjfx_pkg::*;
#(
  parameter int MAX_FRAME   = 524288,
  parameter int MAX_PACKET  = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], packet_len[18:8], zero fill
  input  logic        in_tuser,   // packet_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // address[18:0], byte_value[26:19], frame_length[46:27]
  output logic        out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  logic [FLEN_W-1:0] min_frame_r;
  logic              q_full;
  logic              push;
  logic [BYTE_W-1:0] push_byte;
  logic              q_valid;
  logic [BYTE_W-1:0] q_byte;
  logic              q_pop;
  result_t           res;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frame_r <= MIN_FRAME_RST;
    end else if (cfg_valid) begin
      min_frame_r <= cfg_data;
    end
  end

  mjfx_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_en     (in_tvalid && in_tready),
    .data_byte   (in_tdata[7:0]),
    .packet_start(in_tuser),
    .packet_len  (in_tdata[18:8]),
    .push        (push),
    .push_byte   (push_byte)
  );

  mjfx_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_byte),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_byte)
  );

  mjfx_back #(
    .MAX_FRAME(MAX_FRAME)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .min_frame(min_frame_r),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {1'b0, res.frame_length, res.byte_value, res.address};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

/* test/testbench.sv */
module testbench;
  import mjfx_pkg::*;

  localparam int FRAME_CAP  = 524288;
  localparam int PACKET_CAP = 1024;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // data_byte[7:0], packet_len[18:8], zero fill
  logic        in_tuser;   // packet_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // address[18:0], byte_value[26:19], frame_length[46:27]
  logic        out_tuser;  // kind
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [19:0] cfg_data;

  uvc_mjpeg_frame_extractor #(
    .MAX_FRAME(FRAME_CAP),
    .MAX_PACKET(PACKET_CAP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // packet and frame tracking
  logic [10:0]       pkt_pos = '0;
  logic [10:0]       pkt_len = '0;
  logic [7:0]        hdr_len = '0;
  logic              pkt_ok = 1'b0;
  logic [FLEN_W-1:0] frame_fill = '0;
  logic [7:0]        last_stored = '0;
  logic [FLEN_W-1:0] min_len = MIN_FRAME_RST;

  result_t    fb_ops[$];
  result_t    batch[2];
  int         batch_n;
  logic [7:0] stream_q[$];
  int         errors = 0;
  bit         quiet = 1'b0;
  int         stall_left = 0;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 3))
      0: return MARK_BYTE;
      1: return SOI_BYTE;
      2: return EOI_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_op(kind_t k, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] v,
                                 logic [FLEN_W-1:0] n);
    batch[batch_n].kind         = k;
    batch[batch_n].address      = a;
    batch[batch_n].byte_value   = v;
    batch[batch_n].frame_length = n;
    batch[batch_n].last         = 1'b0;
    batch_n++;
  endfunction

  function automatic void track_packet(logic [7:0] b, logic start, logic [10:0] len);
    logic after_mark;
    if (start) begin
      pkt_pos = '0;
      pkt_len = len;
      hdr_len = b;
      pkt_ok  = len >= 11'd2 && b >= 8'd2 && 11'(b) <= len && len <= 11'(PACKET_CAP);
      return;
    end
    batch_n = 0;
    if (pkt_pos != 11'h7FF) pkt_pos++;
    if (pkt_ok && pkt_pos >= 11'(hdr_len) && pkt_pos < pkt_len) begin
      after_mark = (last_stored == MARK_BYTE);
      if (frame_fill == '0) begin
        if (b == MARK_BYTE) begin
          add_op(KIND_STORE, '0, b, '0);
          frame_fill  = 20'd1;
          last_stored = b;
        end
      end else if (after_mark && b == SOI_BYTE) begin
        // restart of the frame
        add_op(KIND_STORE, 19'd0, MARK_BYTE, '0);
        add_op(KIND_STORE, 19'd1, SOI_BYTE, '0);
        frame_fill  = 20'd2;
        last_stored = SOI_BYTE;
      end else if (frame_fill == 20'd1 && b != SOI_BYTE) begin
        frame_fill = (b == MARK_BYTE) ? 20'd1 : 20'd0;
      end else begin
        if (frame_fill < 20'(FRAME_CAP)) begin
          add_op(KIND_STORE, frame_fill[ADDR_W-1:0], b, '0);
          frame_fill++;
          last_stored = b;
        end else begin
          frame_fill = '0;
        end
        if (after_mark && b == EOI_BYTE) begin
          if (frame_fill != '0 && frame_fill >= min_len) add_op(KIND_DONE, '0, '0, frame_fill);
          frame_fill = '0;
        end
      end
    end
    for (int i = 0; i < batch_n; i++) begin
      if (i == batch_n - 1) batch[i].last = 1'b1;
      fb_ops.push_back(batch[i]);
    end
  endfunction

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 100) $error("%s: expected %0d, actual %0d", field, want, got);
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fb_ops.size() == 0) begin
        errors++;
        if (errors <= 100) $error("result beat with nothing expected, kind %0d", out_tuser);
      end else begin
        want = fb_ops.pop_front();
        if (out_tuser !== want.kind) report("kind", 32'(want.kind), 32'(out_tuser));
        if (out_tdata[18:0] !== want.address)
          report("address", 32'(want.address), 32'(out_tdata[18:0]));
        if (out_tdata[26:19] !== want.byte_value)
          report("byte_value", 32'(want.byte_value), 32'(out_tdata[26:19]));
        if (out_tdata[46:27] !== want.frame_length)
          report("frame_length", 32'(want.frame_length), 32'(out_tdata[46:27]));
        if (out_tlast !== want.last) report("last", 32'(want.last), 32'(out_tlast));
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_beat(logic [7:0] b, logic start, logic [10:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, len, b};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_packet(b, start, len);
  endtask

  // header bytes are junk, payload comes from stream_q, bytes past the length are random
  task automatic send_packet(logic [7:0] hdr, logic [10:0] len, int nbytes);
    logic [7:0] b;
    send_beat(hdr, 1'b1, len);
    for (int p = 1; p <= nbytes; p++) begin
      if (p < int'(hdr)) b = junk_byte();
      else if (p < int'(len) && stream_q.size() != 0) b = stream_q.pop_front();
      else b = 8'($urandom_range(0, 255));
      send_beat(b, 1'b0, 11'($urandom_range(0, 2047)));
    end
  endtask

  task automatic send_stream(int hdr_max, int chunk_max, output int beats);
    int hdr;
    int n;
    int extra;
    beats = 0;
    while (stream_q.size() != 0) begin
      hdr = $urandom_range(2, hdr_max);
      n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, chunk_max);
      if (n > stream_q.size()) n = stream_q.size();
      extra = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
      send_packet(8'(hdr), 11'(hdr + n), hdr + n - 1 + extra);
      beats += hdr + n + extra;
    end
  endtask

  function automatic void add_frame(int len, bit eoi, int mark_pct);
    stream_q.push_back(MARK_BYTE);
    stream_q.push_back(SOI_BYTE);
    for (int i = 0; i < len - 4; i++) begin
      if ($urandom_range(0, 99) < mark_pct) begin
        stream_q.push_back(MARK_BYTE);
        stream_q.push_back(junk_byte());
        i++;
      end else begin
        stream_q.push_back(8'($urandom_range(0, 254)));
      end
    end
    if (eoi) begin
      stream_q.push_back(MARK_BYTE);
      stream_q.push_back(EOI_BYTE);
    end else begin
      stream_q.push_back(8'($urandom_range(0, 254)));
      stream_q.push_back(8'($urandom_range(0, 254)));
    end
  endfunction

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fb_ops.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_min_frame(logic [19:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_len = v;
  endtask

  task automatic test_stray_bytes();
    send_beat(MARK_BYTE, 1'b0, 11'h7FF);
    send_beat(SOI_BYTE, 1'b0, 11'h000);
    send_beat(8'h00, 1'b0, 11'h155);
    send_beat(MARK_BYTE, 1'b0, 11'h2AA);
    send_beat(EOI_BYTE, 1'b0, 11'h400);
  endtask

  task automatic test_reset_threshold();
    int beats;
    add_frame(60, 1'b1, 0);
    add_frame(1000, 1'b1, 0);
    send_stream(6, 200, beats);
  endtask

  task automatic test_frame_markers();
    logic [7:0] seq [21] = '{8'h12, MARK_BYTE, 8'h34, MARK_BYTE, MARK_BYTE, SOI_BYTE, 8'h01,
                             MARK_BYTE, SOI_BYTE, 8'h02, MARK_BYTE, MARK_BYTE, EOI_BYTE,
                             MARK_BYTE, EOI_BYTE, SOI_BYTE, EOI_BYTE, MARK_BYTE, SOI_BYTE,
                             MARK_BYTE, EOI_BYTE};
    int beats;
    write_min_frame(20'd0);
    foreach (seq[i]) stream_q.push_back(seq[i]);
    send_stream(4, 5, beats);
  endtask

  task automatic test_bad_packets();
    logic [7:0]  hdrs [7] = '{8'd5, 8'd1, 8'd0, 8'd1, 8'd11, 8'd2, 8'd255};
    logic [10:0] lens [7] = '{11'd0, 11'd1, 11'd10, 11'd10, 11'd10, 11'd1025, 11'd2047};
    for (int i = 0; i < 7; i++) begin
      stream_q.delete();
      stream_q.push_back(MARK_BYTE);
      stream_q.push_back(SOI_BYTE);
      stream_q.push_back(MARK_BYTE);
      stream_q.push_back(EOI_BYTE);
      send_packet(hdrs[i], lens[i], 6);
    end
    stream_q.delete();
    // header only, then bytes past the length
    send_beat(8'd2, 1'b1, 11'd2);
    send_beat(8'h00, 1'b0, 11'd0);
    send_beat(MARK_BYTE, 1'b0, 11'h7FF);
    send_beat(SOI_BYTE, 1'b0, 11'd0);
    // largest header and packet, cut short by the next start
    stream_q.push_back(MARK_BYTE);
    stream_q.push_back(SOI_BYTE);
    stream_q.push_back(8'h5A);
    stream_q.push_back(MARK_BYTE);
    stream_q.push_back(EOI_BYTE);
    send_packet(8'd255, 11'(PACKET_CAP), 262);
    stream_q.delete();
  endtask

  task automatic test_min_frame();
    int beats;
    write_min_frame(20'd10);
    add_frame(9, 1'b1, 0);
    add_frame(10, 1'b1, 0);
    send_stream(6, 8, beats);
    write_min_frame(20'(FRAME_CAP));
    add_frame(40, 1'b1, 3);
    add_frame(6, 1'b1, 0);
    send_stream(6, 8, beats);
    write_min_frame(20'd1);
    add_frame(4, 1'b1, 0);
    send_stream(3, 4, beats);
  endtask

  task automatic test_random();
    logic [19:0] lim;
    int sent;
    int beats;
    int pick;
    int hdr;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: lim = 20'd0;
        1: lim = 20'(FRAME_CAP);
        3: lim = 20'($urandom_range(0, FRAME_CAP));
        default: lim = 20'($urandom_range(1, 48));
      endcase
      write_min_frame(lim);
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(0, 7) == 0) quiet = !quiet;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          repeat ($urandom_range(1, 3))
            add_frame($urandom_range(4, 40), $urandom_range(0, 9) != 0, 4);
          send_stream(12, 40, beats);
          sent += beats;
        end else if (pick == 7) begin
          send_packet(8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                      $urandom_range(0, 12));
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 4)) send_beat(junk_byte(), 1'b0, 11'($urandom_range(0, 2047)));
        end else begin
          // packet cut short by the next start
          add_frame($urandom_range(6, 30), 1'b1, 4);
          hdr = $urandom_range(2, 8);
          send_packet(8'(hdr), 11'(hdr + 40), $urandom_range(hdr, hdr + 20));
          stream_q.delete();
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_stray_bytes();
    test_reset_threshold();
    test_frame_markers();
    test_bad_packets();
    test_min_frame();
    test_random();
    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* uvc_mjpeg_frame_extractor.f */
hw/rtl/mjfx_pkg.sv
hw/rtl/mjfx_front.sv
hw/rtl/mjfx_queue.sv
hw/rtl/mjfx_back.sv
hw/rtl/uvc_mjpeg_frame_extractor.sv
test/testbench.sv
